/* sv/sbl_pkg.sv */
`default_nettype none

package sbl_pkg;

  localparam int DATA_W   = 8;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SORTED_INS = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_READ_ALL   = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

/* sv/sbl_if.sv */
`default_nettype none

interface sbl_in_if;
  logic                                valid;
  logic                                ready;
  logic [sbl_pkg::ACTION_W-1:0]        action;
  logic signed [sbl_pkg::DATA_W-1:0]   value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface sbl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sbl_pkg::DATA_W-1:0]   item;
  logic [sbl_pkg::STATUS_W-1:0]        status;
  logic [sbl_pkg::COUNT_W-1:0]         count;
  logic                                last;

  modport source (output valid, item, status, count, last, input ready);
  modport sink   (input valid, item, status, count, last, output ready);
endinterface

`default_nettype wire

/* sv/sbl_mem.sv */
`default_nettype none

// Entry store: one write port, one read port with registered data.
module sbl_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire sbl_pkg::data_t  wdata,
  input  wire logic [AW-1:0]   raddr,
  output sbl_pkg::data_t       rdata
);

  sbl_pkg::data_t ram_r [DEPTH];
  sbl_pkg::data_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      ram_r[waddr] <= wdata;
    end
    rdata_r <= ram_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/sbl_seq.sv */
`default_nettype none

// Sequencer: walks the entry store one entry per cycle with a single compare
// unit, holding while the result register stalls, and drives that register.
module sbl_seq #(
  parameter int CAPACITY = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int OW = $clog2(CAPACITY + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  sbl_in_if.sink              in_if,
  sbl_out_if.source           out_if,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output sbl_pkg::data_t      mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  wire sbl_pkg::data_t mem_rdata
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_UP   = 7'b0000100,
    S_PUT  = 7'b0001000,
    S_DN   = 7'b0010000,
    S_READ = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [sbl_pkg::ACTION_W-1:0]  act_r, act_nxt;
  sbl_pkg::data_t                val_r, val_nxt;
  logic [OW-1:0]                 occ_r, occ_nxt;
  logic [OW-1:0]                 idx_r, idx_nxt;
  logic [OW-1:0]                 pos_r, pos_nxt;
  logic [sbl_pkg::STATUS_W-1:0]  st_r, st_nxt;

  logic                          out_valid_r, out_valid_nxt;
  sbl_pkg::data_t                out_item_r, out_item_nxt;
  logic [sbl_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [sbl_pkg::COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [OW-1:0]                 idx_plus, idx_minus, occ_plus, occ_minus;
  logic                          is_full, is_empty, out_free, hit, at_end;
  logic [OW+sbl_pkg::COUNT_W-1:0] occ_ext;

  assign idx_plus  = idx_r + 1'b1;
  assign idx_minus = idx_r - 1'b1;
  assign occ_plus  = occ_r + 1'b1;
  assign occ_minus = occ_r - 1'b1;
  assign is_full   = (occ_r >= OW'(CAPACITY));
  assign is_empty  = (occ_r == '0);
  assign out_free  = !out_valid_r || out_if.ready;
  assign at_end    = (idx_plus == occ_r);
  assign occ_ext   = {{sbl_pkg::COUNT_W{1'b0}}, occ_r};

  // Shared compare: strictly larger for sorted insert, equal for removal.
  assign hit = (act_r == sbl_pkg::ACT_SORTED_INS) ? (mem_rdata > val_r)
                                                  : (mem_rdata == val_r);

  assign in_if.ready   = (state_r == S_IDLE);
  assign out_if.valid  = out_valid_r;
  assign out_if.item   = out_item_r;
  assign out_if.status = out_status_r;
  assign out_if.count  = out_count_r;
  assign out_if.last   = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    val_nxt        = val_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    st_nxt         = st_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r[AW-1:0];
    mem_wdata      = val_r;
    mem_raddr      = idx_r[AW-1:0];
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_item_nxt   = out_item_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          act_nxt   = in_if.action;
          val_nxt   = in_if.value;
          st_nxt    = sbl_pkg::ST_OK;
          idx_nxt   = '0;
          pos_nxt   = '0;
          mem_raddr = '0;
          state_nxt = S_DONE;
          unique case (in_if.action)
            sbl_pkg::ACT_PUSH_FRONT: begin
              if (is_full) begin
                st_nxt = sbl_pkg::ST_FULL;
              end else if (is_empty) begin
                state_nxt = S_PUT;
              end else begin
                mem_raddr = occ_minus[AW-1:0];
                idx_nxt   = occ_minus;
                state_nxt = S_UP;
              end
            end
            sbl_pkg::ACT_PUSH_BACK: begin
              if (is_full) begin
                st_nxt = sbl_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = occ_r[AW-1:0];
                mem_wdata = in_if.value;
                occ_nxt   = occ_plus;
              end
            end
            sbl_pkg::ACT_SORTED_INS: begin
              if (is_full) begin
                st_nxt = sbl_pkg::ST_FULL;
              end else if (is_empty) begin
                state_nxt = S_PUT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            sbl_pkg::ACT_POP_FRONT: begin
              if (is_empty) begin
                st_nxt = sbl_pkg::ST_EMPTY;
              end else if (occ_r == OW'(1)) begin
                occ_nxt = occ_minus;
              end else begin
                mem_raddr = AW'(1);
                idx_nxt   = OW'(1);
                state_nxt = S_DN;
              end
            end
            sbl_pkg::ACT_POP_BACK: begin
              if (is_empty) begin
                st_nxt = sbl_pkg::ST_EMPTY;
              end else begin
                occ_nxt = occ_minus;
              end
            end
            sbl_pkg::ACT_REMOVE: begin
              if (is_empty) begin
                st_nxt = sbl_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            sbl_pkg::ACT_READ_ALL: begin
              if (is_empty) begin
                st_nxt = sbl_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              st_nxt = sbl_pkg::ST_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          pos_nxt = idx_r;
          if (act_r == sbl_pkg::ACT_SORTED_INS) begin
            mem_raddr = occ_minus[AW-1:0];
            idx_nxt   = occ_minus;
            state_nxt = S_UP;
          end else if (at_end) begin
            occ_nxt   = occ_minus;
            state_nxt = S_DONE;
          end else begin
            mem_raddr = idx_plus[AW-1:0];
            idx_nxt   = idx_plus;
            state_nxt = S_DN;
          end
        end else if (at_end) begin
          if (act_r == sbl_pkg::ACT_SORTED_INS) begin
            pos_nxt   = occ_r;
            state_nxt = S_PUT;
          end else begin
            st_nxt    = sbl_pkg::ST_NOTFOUND;
            state_nxt = S_DONE;
          end
        end else begin
          mem_raddr = idx_plus[AW-1:0];
          idx_nxt   = idx_plus;
        end
      end

      S_UP: begin
        // Move entry idx up by one while fetching the one below it.
        mem_we    = 1'b1;
        mem_waddr = idx_plus[AW-1:0];
        mem_wdata = mem_rdata;
        if (idx_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          mem_raddr = idx_minus[AW-1:0];
          idx_nxt   = idx_minus;
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        occ_nxt   = occ_plus;
        state_nxt = S_DONE;
      end

      S_DN: begin
        // Move entry idx down by one while fetching the next one.
        mem_we    = 1'b1;
        mem_waddr = idx_minus[AW-1:0];
        mem_wdata = mem_rdata;
        if (at_end) begin
          occ_nxt   = occ_minus;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = idx_plus[AW-1:0];
          idx_nxt   = idx_plus;
        end
      end

      S_READ: begin
        // On a stall the default read address re-fetches the same entry.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_item_nxt   = mem_rdata;
          out_status_nxt = sbl_pkg::ST_OK;
          out_count_nxt  = occ_ext[sbl_pkg::COUNT_W-1:0];
          out_last_nxt   = at_end;
          if (at_end) begin
            state_nxt = S_IDLE;
          end else begin
            mem_raddr = idx_plus[AW-1:0];
            idx_nxt   = idx_plus;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_item_nxt   = '0;
          out_status_nxt = st_r;
          out_count_nxt  = occ_ext[sbl_pkg::COUNT_W-1:0];
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    st_r         <= st_nxt;
    out_item_r   <= out_item_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

`default_nettype wire

/* sv/sorted_byte_list_engine.sv */
`default_nettype none

// Bounded ordered list of signed bytes, up to CAPACITY entries, held front
// to back in a single-port-write, single-port-read entry store. Each transfer
// on in_if names one action: push front, push back, sorted insert (before
// the first strictly larger entry), pop front, pop back, remove the
// frontmost equal entry, or read all. Every action but read all returns one
// transfer on out_if with a status and the new count; read all returns every
// entry front to back with last on the final one, or one transfer with
// status empty when the list holds nothing. in_if.ready is high only while
// the sequencer is idle, and the next item may be taken while the final
// result still sits in the output register. With n entries held: push
// back and pop back act at accept, and rejected actions change
// nothing; pop front shifts n - 1 entries down; push front shifts n
// entries up, then writes; sorted insert before the entry at position p
// scans p + 1 entries, shifts n - p entries up, then writes, or scans all
// n and writes when it lands at the back; remove scans for the value and,
// when found, shifts the entries behind it down; read all returns each
// entry in turn. The entry store moves or compares one entry per cycle
// through its one read and one write port; read all holds while out_if
// stalls. Entries are not cleared at reset; only occupied entries are ever
// read.
module sorted_byte_list_engine #(
  parameter int CAPACITY = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sbl_in_if.sink     in_if,
  sbl_out_if.source  out_if
);

  localparam int AW = $clog2(CAPACITY);

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  sbl_pkg::data_t  mem_wdata;
  logic [AW-1:0]   mem_raddr;
  sbl_pkg::data_t  mem_rdata;

  // Sequencer, compare unit and result register.
  sbl_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Entry store.
  sbl_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
